@@ sv/xcfe_pkg.sv @@
`default_nettype none

package xcfe_pkg;

  // Default maximum frame length, in bytes.
  localparam int MAX_LEN_DEF = 15;

  // Shortest legal frame: separator, length and checksum.
  localparam logic [7:0] MIN_LEN = 8'd3;

  // Separator value after reset.
  localparam logic [7:0] SEP_RESET = 8'h55;

  // At most this many result beats are produced for one input beat.
  localparam int RES_LIMIT = 64;
  localparam int RES_CNT_W = $clog2(RES_LIMIT + 1);

  // Result kinds.
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_ERR   = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic feed_in;    // parse the input beat
    logic feed_rep;   // parse the byte read back from the replay buffer
    logic st_rd;      // read the frame store at the pass index
    logic rb_rd;      // read the replay buffer at the replay pointer
    logic emit_byte;  // send one stored frame byte, copying the tail if needed
    logic copy_byte;  // copy one stored tail byte into the replay buffer
  } xcfe_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;   // output register can take a beat this cycle
    logic body_end;   // the next parsed byte is a checksum byte
    logic cmpl_good;  // that checksum matches
    logic cmpl_copy;  // the frame tail must be copied before replay
    logic idx_last;   // pass index is at the last frame byte
    logic rep_pend;   // replay bytes are waiting
  } xcfe_sts_t;

endpackage

`default_nettype wire

@@ sv/xor_checked_frame_extractor_top.sv @@
`default_nettype none

// Length-prefixed frame extractor with XOR checksum. Bytes arrive one per
// input beat; a frame is separator, length N (3 to MAX_LEN), N-3 payload
// bytes and a checksum equal to the XOR of all preceding frame bytes. A good
// frame leaves as N result beats with last set on the checksum byte; a bad
// length gives one error beat (kind 1, byte 0, last 1); a bad checksum gives
// nothing. A separator inside the payload causes the bytes from that point
// to be parsed again once the frame closes. When a good frame closes, each
// byte is read from the single-port frame store before it is placed in the
// output register, and a check for pending replay bytes follows. A bad
// checksum leads only to that check, after a copy of the tail bytes to the
// replay buffer when a restart is pending and the checksum byte came from
// the input rather than from a replay. Each replayed byte goes through a
// buffer read, a parse and a dispatch. The block takes no input beat while
// it emits, copies or replays, and stalls when the output is held off. The
// separator register may be written at any time through the cfg channel,
// which is always ready.
module xor_checked_frame_extractor_top import xcfe_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_kind,
  output logic [7:0]      out_frame_byte,
  output logic            out_last,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_separator_value
);

  xcfe_cmd_t cmd;
  xcfe_sts_t sts;

  // The separator register takes a write in every cycle.
  assign cfg_ready = 1'b1;

  xcfe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  xcfe_dpath #(
    .MAX_LEN (MAX_LEN)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_separator_value (cfg_separator_value),
    .in_data_byte        (in_data_byte),
    .out_ready           (out_ready),
    .out_valid           (out_valid),
    .out_kind            (out_kind),
    .out_frame_byte      (out_frame_byte),
    .out_last            (out_last),
    .cmd                 (cmd),
    .sts                 (sts)
  );

endmodule

`default_nettype wire

@@ sv/xcfe_ctrl.sv @@
`default_nettype none

module xcfe_ctrl import xcfe_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire xcfe_sts_t sts,
  output xcfe_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_EM_RD    = 3'd1;
  localparam logic [2:0] S_EM_WR    = 3'd2;
  localparam logic [2:0] S_CP_RD    = 3'd3;
  localparam logic [2:0] S_CP_WR    = 3'd4;
  localparam logic [2:0] S_NEXT     = 3'd5;
  localparam logic [2:0] S_REP_RD   = 3'd6;
  localparam logic [2:0] S_REP_FEED = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic [2:0] after_cmpl;

  // Where to go once a checksum byte has been parsed.
  always_comb begin
    if (sts.cmpl_good) begin
      after_cmpl = S_EM_RD;
    end else if (sts.cmpl_copy) begin
      after_cmpl = S_CP_RD;
    end else begin
      after_cmpl = S_NEXT;
    end
  end

  // Sequencer for parsing, frame emission, tail copy and replay.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = sts.out_free;
        if (in_valid && sts.out_free) begin
          cmd.feed_in = 1'b1;
          if (sts.body_end) begin
            state_nxt = after_cmpl;
          end
        end
      end
      S_EM_RD: begin
        cmd.st_rd = 1'b1;
        state_nxt = S_EM_WR;
      end
      S_EM_WR: begin
        if (sts.out_free) begin
          cmd.emit_byte = 1'b1;
          state_nxt     = sts.idx_last ? S_NEXT : S_EM_RD;
        end
      end
      S_CP_RD: begin
        cmd.st_rd = 1'b1;
        state_nxt = S_CP_WR;
      end
      S_CP_WR: begin
        cmd.copy_byte = 1'b1;
        state_nxt     = sts.idx_last ? S_NEXT : S_CP_RD;
      end
      S_NEXT: begin
        state_nxt = sts.rep_pend ? S_REP_RD : S_IDLE;
      end
      S_REP_RD: begin
        cmd.rb_rd = 1'b1;
        state_nxt = S_REP_FEED;
      end
      S_REP_FEED: begin
        if (sts.out_free) begin
          cmd.feed_rep = 1'b1;
          state_nxt    = sts.body_end ? after_cmpl : S_NEXT;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // At most one datapath operation is issued in any cycle.
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command issued");

  // An input beat that does not close a frame leaves the controller idle.
  a_idle_stays: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid && in_ready && !sts.body_end) |=> state_r == S_IDLE)
    else $error("controller left idle without a completed frame");

endmodule

`default_nettype wire

@@ sv/xcfe_dpath.sv @@
`default_nettype none

module xcfe_dpath import xcfe_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  input  wire logic [7:0] cfg_separator_value,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       out_ready,
  output logic            out_valid,
  output logic            out_kind,
  output logic [7:0]      out_frame_byte,
  output logic            out_last,
  input  wire xcfe_cmd_t  cmd,
  output xcfe_sts_t       sts
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int LW = $clog2(MAX_LEN + 1);

  localparam logic [1:0] PH_HUNT   = 2'd0;
  localparam logic [1:0] PH_LENGTH = 2'd1;
  localparam logic [1:0] PH_BODY   = 2'd2;

  // Frame store and replay buffer.
  logic [7:0] store_mem [MAX_LEN];
  logic [7:0] rb_mem [MAX_LEN];
  logic [7:0] st_q;
  logic [7:0] rb_q;

  logic [7:0]           sep_r, sep_nxt;
  logic [1:0]           phase_r, phase_nxt;
  logic [LW-1:0]        n_r, n_nxt;
  logic [AW-1:0]        pos_r, pos_nxt;
  logic [7:0]           xor_r, xor_nxt;
  logic [AW-1:0]        rs_r, rs_nxt;
  logic [AW-1:0]        rl_r, rl_nxt;
  logic [AW-1:0]        j_r, j_nxt;
  logic                 in_rb_r, in_rb_nxt;
  logic                 copy_r, copy_nxt;
  logic [AW-1:0]        idx_r, idx_nxt;
  logic [LW-1:0]        rd_r, rd_nxt;
  logic [LW-1:0]        last_r, last_nxt;
  logic [RES_CNT_W-1:0] res_cnt_r, res_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_kind_r;
  logic [7:0]           out_byte_r;
  logic                 out_last_r;

  logic                 feed;
  logic [7:0]           fb;
  logic                 is_sep;
  logic                 len_bad;
  logic [LW-1:0]        n_m1;
  logic                 body_end;
  logic                 jump;
  logic                 restart;
  logic                 cmpl_good;
  logic                 err;
  logic                 st_we;
  logic [AW-1:0]        st_wa;
  logic                 rb_we;
  logic [AW-1:0]        rb_wa;
  logic                 idx_last;
  logic                 out_free;
  logic [RES_CNT_W-1:0] cnt_base;
  logic                 load;

  // Byte being parsed and the tests on it.
  always_comb begin
    feed      = cmd.feed_in | cmd.feed_rep;
    fb        = cmd.feed_rep ? rb_q : in_data_byte;
    is_sep    = (fb == sep_r);
    len_bad   = (fb < MIN_LEN) || (fb > 8'(MAX_LEN));
    n_m1      = n_r - LW'(1);
    body_end  = (phase_r == PH_BODY) && (LW'(pos_r) == n_m1);
    jump      = cmd.feed_rep && in_rb_r;
    restart   = (rs_r != '0);
    cmpl_good = (xor_r == fb);
    err       = feed && (phase_r == PH_LENGTH) && len_bad;
    idx_last  = (LW'(idx_r) == n_m1);
    out_free  = !out_valid_r || out_ready;
  end

  // Frame store write position for the parsed byte.
  always_comb begin
    st_we = 1'b0;
    st_wa = pos_r;
    case (phase_r)
      PH_HUNT: begin
        st_we = feed && is_sep;
        st_wa = '0;
      end
      PH_LENGTH: begin
        st_we = feed && !len_bad;
        st_wa = AW'(1);
      end
      PH_BODY: begin
        st_we = feed;
        st_wa = pos_r;
      end
      default: begin
        st_we = 1'b0;
      end
    endcase
  end

  // Tail bytes go to the replay buffer from its start.
  always_comb begin
    rb_we = cmd.copy_byte || (cmd.emit_byte && copy_r && (idx_r >= rl_r));
    rb_wa = idx_r - rl_r;
  end

  // Parser, pass index and replay pointer.
  always_comb begin
    sep_nxt   = cfg_valid ? cfg_separator_value : sep_r;
    phase_nxt = phase_r;
    n_nxt     = n_r;
    pos_nxt   = pos_r;
    xor_nxt   = xor_r;
    rs_nxt    = rs_r;
    rl_nxt    = rl_r;
    j_nxt     = j_r;
    in_rb_nxt = in_rb_r;
    copy_nxt  = copy_r;
    idx_nxt   = idx_r;
    rd_nxt    = cmd.feed_rep ? rd_r + LW'(1) : rd_r;
    last_nxt  = last_r;
    if (cmd.emit_byte || cmd.copy_byte) begin
      idx_nxt = idx_r + AW'(1);
    end
    if (feed) begin
      case (phase_r)
        PH_HUNT: begin
          if (is_sep) begin
            xor_nxt   = fb;
            phase_nxt = PH_LENGTH;
            in_rb_nxt = cmd.feed_rep;
            j_nxt     = rd_r[AW-1:0];
          end
        end
        PH_LENGTH: begin
          if (len_bad) begin
            phase_nxt = PH_HUNT;
          end else begin
            xor_nxt   = xor_r ^ fb;
            n_nxt     = fb[LW-1:0];
            pos_nxt   = AW'(2);
            rs_nxt    = '0;
            phase_nxt = PH_BODY;
          end
        end
        PH_BODY: begin
          if (!body_end) begin
            xor_nxt = xor_r ^ fb;
            if (is_sep && !restart) begin
              rs_nxt = pos_r;
            end
            pos_nxt = pos_r + AW'(1);
          end else begin
            // Checksum byte: set up emission, tail copy and replay.
            phase_nxt = PH_HUNT;
            rs_nxt    = '0;
            rl_nxt    = rs_r;
            copy_nxt  = restart && !jump;
            idx_nxt   = cmpl_good ? '0 : rs_r;
            if (restart) begin
              if (jump) begin
                rd_nxt = LW'(j_r) + LW'(rs_r);
              end else begin
                rd_nxt   = '0;
                last_nxt = n_m1 - LW'(rs_r);
              end
            end
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end
  end

  // Result counting per input beat and the output register.
  always_comb begin
    cnt_base      = cmd.feed_in ? '0 : res_cnt_r;
    load          = (err || cmd.emit_byte) && (cnt_base < RES_CNT_W'(RES_LIMIT));
    res_cnt_nxt   = cnt_base + {{(RES_CNT_W - 1){1'b0}}, load};
    out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  // Memories with registered reads.
  always_ff @(posedge clk) begin
    if (st_we) begin
      store_mem[st_wa] <= fb;
    end
    if (cmd.st_rd) begin
      st_q <= store_mem[idx_r];
    end
    if (rb_we) begin
      rb_mem[rb_wa] <= st_q;
    end
    if (cmd.rb_rd) begin
      rb_q <= rb_mem[rd_r[AW-1:0]];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r       <= SEP_RESET;
      phase_r     <= PH_HUNT;
      n_r         <= '0;
      pos_r       <= '0;
      xor_r       <= '0;
      rs_r        <= '0;
      in_rb_r     <= 1'b0;
      copy_r      <= 1'b0;
      rd_r        <= LW'(1);
      last_r      <= '0;
      res_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sep_r       <= sep_nxt;
      phase_r     <= phase_nxt;
      n_r         <= n_nxt;
      pos_r       <= pos_nxt;
      xor_r       <= xor_nxt;
      rs_r        <= rs_nxt;
      in_rb_r     <= in_rb_nxt;
      copy_r      <= copy_nxt;
      rd_r        <= rd_nxt;
      last_r      <= last_nxt;
      res_cnt_r   <= res_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rl_r  <= rl_nxt;
    j_r   <= j_nxt;
    idx_r <= idx_nxt;
    if (load) begin
      out_kind_r <= err ? KIND_ERR : KIND_FRAME;
      out_byte_r <= err ? 8'h00 : st_q;
      out_last_r <= err ? 1'b1 : idx_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_frame_byte = out_byte_r;
  assign out_last       = out_last_r;

  always_comb begin
    sts.out_free  = out_free;
    sts.body_end  = body_end;
    sts.cmpl_good = cmpl_good;
    sts.cmpl_copy = restart && !jump;
    sts.idx_last  = idx_last;
    sts.rep_pend  = (rd_r <= last_r);
  end

  // The replay pointer never runs more than one past the end of the replay.
  a_rd_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, rd_r} <= ({1'b0, last_r} + 1'b1))
    else $error("replay pointer beyond replay end");

  // Inside a frame body the write position stays within the frame.
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY) |-> (LW'(pos_r) < n_r))
    else $error("body position outside frame");

  // A result beat is only produced when the output register can take it.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (err || cmd.emit_byte) |-> out_free)
    else $error("result produced while output register busy");

endmodule

`default_nettype wire

@@ test/xor_checked_frame_extractor_top_tb.sv @@
`default_nettype none

module xor_checked_frame_extractor_top_tb;
  import xcfe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES  = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;
  localparam int BYTES_PER_SET  = 60;

  // Opening bytes with the reset separator: shortest frame, each kind of bad
  // length, a bad checksum, a frame nested in a payload and a checksum byte
  // equal to the separator.
  localparam logic [7:0] OPENING_BYTES [25] = '{
    8'h55, 8'h03, 8'h56,
    8'h55, 8'h00,
    8'h55, 8'h02,
    8'h55, 8'h10,
    8'h55, 8'hFF,
    8'h55, 8'h04, 8'hAA, 8'h00,
    8'h55, 8'h06, 8'h55, 8'h03, 8'h56, 8'h53,
    8'h55, 8'h04, 8'h04, 8'h55
  };

  typedef enum logic [1:0] {SCAN_HUNT, SCAN_LENGTH, SCAN_BODY} scan_phase_t;

  typedef struct {
    logic       kind;
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  // Tracks the parser state of the block and the result beats it owes.
  class frame_tracker;
    logic [7:0]  separator;
    logic [7:0]  frame_mem [MAX_LEN_DEF];
    scan_phase_t phase;
    int          frame_len;
    int          body_pos;
    int          restart_pos;
    logic [7:0]  check_acc;
    int          step_beats;
    frame_beat_t awaited [$];
    int          failures;
    int          bytes_seen;
    int          good_frames;
    int          length_errors;
    int          replays;
    int          beats_checked;

    function new();
      separator = SEP_RESET;
      foreach (frame_mem[i]) frame_mem[i] = 8'h00;
      phase = SCAN_HUNT;
      frame_len = 0;
      body_pos = 0;
      restart_pos = 0;
      check_acc = 8'h00;
      failures = 0;
      bytes_seen = 0;
      good_frames = 0;
      length_errors = 0;
      replays = 0;
      beats_checked = 0;
    endfunction

    function void set_separator(logic [7:0] v);
      separator = v;
    endfunction

    // Beats beyond the per-byte limit are dropped by the block.
    function void await_beat(logic k, logic [7:0] d, logic l);
      frame_beat_t b;
      if (step_beats < RES_LIMIT) begin
        b.kind = k;
        b.data = d;
        b.last = l;
        awaited.push_back(b);
        step_beats++;
      end
    endfunction

    // Parse one accepted byte. A closed frame with a separator in its payload
    // puts its tail back at the head of the work list, so nested restarts are
    // handled before the rest of an outer tail.
    function void note_byte(logic [7:0] b);
      logic [7:0] work [$];
      logic [7:0] cur;
      step_beats = 0;
      bytes_seen++;
      work.push_back(b);
      while (work.size() > 0) begin
        cur = work.pop_front();
        case (phase)
          SCAN_HUNT: begin
            if (cur == separator) begin
              frame_mem[0] = cur;
              check_acc = cur;
              phase = SCAN_LENGTH;
            end
          end
          SCAN_LENGTH: begin
            if (cur < MIN_LEN || cur > MAX_LEN_DEF) begin
              await_beat(KIND_ERR, 8'h00, 1'b1);
              length_errors++;
              phase = SCAN_HUNT;
            end else begin
              frame_mem[1] = cur;
              check_acc ^= cur;
              frame_len = int'(cur);
              body_pos = 2;
              restart_pos = 0;
              phase = SCAN_BODY;
            end
          end
          default: begin
            if (frame_len < MIN_LEN || frame_len > MAX_LEN_DEF || body_pos >= frame_len) begin
              phase = SCAN_HUNT;
            end else begin
              frame_mem[body_pos] = cur;
              if (body_pos < frame_len - 1) begin
                check_acc ^= cur;
                if (cur == separator && restart_pos == 0) restart_pos = body_pos;
                body_pos++;
              end else begin
                if (check_acc == cur) begin
                  for (int i = 0; i < frame_len; i++)
                    await_beat(KIND_FRAME, frame_mem[i], i == frame_len - 1);
                  good_frames++;
                end
                phase = SCAN_HUNT;
                if (restart_pos != 0 && restart_pos < frame_len) begin
                  for (int i = frame_len - 1; i >= restart_pos; i--)
                    work.push_front(frame_mem[i]);
                  replays++;
                end
                restart_pos = 0;
              end
            end
          end
        endcase
      end
    endfunction

    // Compare one output beat with the oldest owed beat.
    function void check_beat(logic k, logic [7:0] d, logic l);
      frame_beat_t exp_beat;
      beats_checked++;
      if (awaited.size() == 0) begin
        $error("unexpected result beat: kind %0d byte 0x%02h last %0d", k, d, l);
        failures++;
      end else begin
        exp_beat = awaited.pop_front();
        if (k !== exp_beat.kind) begin
          $error("kind: expected %0d, got %0d", exp_beat.kind, k);
          failures++;
        end
        if (d !== exp_beat.data) begin
          $error("frame_byte: expected 0x%02h, got 0x%02h", exp_beat.data, d);
          failures++;
        end
        if (l !== exp_beat.last) begin
          $error("last: expected %0d, got %0d", exp_beat.last, l);
          failures++;
        end
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_data_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_kind;
  logic [7:0] out_frame_byte;
  logic       out_last;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_separator_value = 8'h00;

  logic       steady = 1'b0;
  logic       hold_out = 1'b0;
  logic       hold_used = 1'b0;
  int         hold_left = 0;
  int         quiet_cycles = 0;
  int         settings_used = 1;

  frame_tracker tracker;

  xor_checked_frame_extractor_top u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data_byte        (in_data_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_kind            (out_kind),
    .out_frame_byte      (out_frame_byte),
    .out_last            (out_last),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_separator_value (cfg_separator_value)
  );

  always #6 clk = ~clk;

  // Result side: check each accepted beat, then choose the next ready level.
  // The one long hold-off is counted here so the sender keeps offering bytes.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      tracker.check_beat(out_kind, out_frame_byte, out_last);
    end
    if (hold_out && !hold_used) begin
      hold_used <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (steady) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= 33);
    end
  end

  // Give up when no beat moves on any channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $error("no beat accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one byte, after a random gap unless in a steady stretch.
  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = (!steady && $urandom_range(0, 99) < 33) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_byte(b);
  endtask

  // Stop offering, wait for every owed beat, then let any replay finish.
  task automatic drain_block();
    in_valid <= 1'b0;
    while (tracker.awaited.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_separator(logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_separator_value <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_separator(v);
    cfg_valid <= 1'b0;
  endtask

  // One random stretch of the stream: mostly well-formed frames with random
  // payloads (some holding separators or whole inner frames), plus bad
  // checksums, bad lengths, cut-short frames and loose noise.
  task automatic send_segment(output int counted);
    logic [7:0] seg [$];
    logic [7:0] sep;
    logic [7:0] acc;
    int pick;
    int n;
    int m;
    int at;
    sep = tracker.separator;
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      n = $urandom_range(MIN_LEN, MAX_LEN_DEF);
      seg.push_back(sep);
      seg.push_back(n[7:0]);
      for (int i = 0; i < n - 3; i++)
        seg.push_back(($urandom_range(0, 99) < 15) ? sep : 8'($urandom));
      // Place a complete inner frame inside the payload.
      if (n - 3 >= 3 && $urandom_range(0, 3) == 0) begin
        m = $urandom_range(3, n - 3);
        at = 2 + $urandom_range(0, n - 3 - m);
        seg[at] = sep;
        seg[at + 1] = m[7:0];
        acc = sep ^ m[7:0];
        for (int i = 2; i < m - 1; i++) acc ^= seg[at + i];
        seg[at + m - 1] = acc;
      end
      // Now and then force the checksum byte to equal the separator.
      if (n > 3 && $urandom_range(0, 7) == 0) begin
        acc = 8'h00;
        for (int i = 0; i < n - 2; i++) acc ^= seg[i];
        seg[n - 2] = acc ^ sep;
      end
      acc = 8'h00;
      for (int i = 0; i < n - 1; i++) acc ^= seg[i];
      seg.push_back((pick < 60) ? acc : acc ^ 8'($urandom_range(1, 255)));
    end else if (pick < 85) begin
      seg.push_back(sep);
      seg.push_back(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 2))
                                                : 8'($urandom_range(16, 255)));
    end else if (pick < 93) begin
      n = $urandom_range(MIN_LEN, MAX_LEN_DEF);
      seg.push_back(sep);
      seg.push_back(n[7:0]);
      m = $urandom_range(0, n - 3);
      for (int i = 0; i < m; i++) seg.push_back(8'($urandom));
    end else begin
      m = $urandom_range(1, 5);
      for (int i = 0; i < m; i++) seg.push_back(8'($urandom));
    end
    counted = (pick < 93) ? seg.size() : 0;
    foreach (seg[i]) send_byte(seg[i]);
  endtask

  initial begin
    logic [7:0] set_values [4];
    int sent;
    int got;
    tracker = new();
    set_values[0] = 8'h00;
    set_values[1] = 8'hFF;
    set_values[2] = 8'($urandom_range(1, 254));
    set_values[3] = SEP_RESET;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening with the separator left at its reset value.
    foreach (OPENING_BYTES[i]) send_byte(OPENING_BYTES[i]);

    // Random stretches, one per separator setting. The first runs with no
    // idling on either side; the second begins with the long output hold-off.
    for (int s = 0; s < 4; s++) begin
      drain_block();
      write_separator(set_values[s]);
      settings_used++;
      steady <= (s == 0);
      hold_out <= (s == 1);
      sent = 0;
      while (sent < BYTES_PER_SET) begin
        send_segment(got);
        sent += got;
      end
    end
    steady <= 1'b0;
    drain_block();

    $display("Covered %0d input bytes under %0d separator settings: %0d good frames,",
             tracker.bytes_seen, settings_used, tracker.good_frames);
    $display("%0d length errors, %0d restarts and %0d result beats checked.",
             tracker.length_errors, tracker.replays, tracker.beats_checked);
    if (tracker.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
sv/xcfe_pkg.sv
sv/xcfe_ctrl.sv
sv/xcfe_dpath.sv
sv/xor_checked_frame_extractor_top.sv
test/xor_checked_frame_extractor_top_tb.sv
